// ===== rtl/sdtq_pkg.sv =====
// Shared types and constants for the sorted deadline timer queue.
package sdtq_pkg;

    // Request codes on the input channel
    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Result kinds on the output channel
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ACCEPT = 2'd0;
    localparam t_kind KIND_FULL   = 2'd1;
    localparam t_kind KIND_FIRED  = 2'd2;

    // Microseconds per millisecond and derived widths
    localparam int unsigned REM_W     = 10;
    localparam logic [REM_W-1:0] US_PER_MS = 10'd1000;
    localparam int unsigned DELAY_W   = 32;
    localparam int unsigned TAG_W     = 32;
    localparam int unsigned PROD_W    = DELAY_W + REM_W;

    // Millisecond remainder unit: byte residues summed, then folded
    localparam int unsigned SUM_W     = 21;
    localparam int unsigned REM_STEPS = 3;
    localparam logic [4:0]  FOLD_1024 = 5'd24;    // 1024 mod 1000

    // Fire group size limit per tick
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned N_W         = 5;

    // Weight of byte idx of a time value, modulo 1000
    function automatic logic [REM_W-1:0] byte_weight(input logic [2:0] idx);
        logic [REM_W-1:0] w;
        unique case (idx)
            3'd0: w = 10'd1;
            3'd1: w = 10'd256;
            3'd2: w = 10'd536;
            3'd3: w = 10'd216;
            3'd4: w = 10'd296;
            3'd5: w = 10'd776;
            3'd6: w = 10'd656;
            3'd7: w = 10'd936;
        endcase
        return w;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic  accept;      // latch the input transaction
        logic  mul;         // delay times 1000
        logic  add;         // deadline and insert walk setup
        logic  ins_rd;      // read address follows the insert pointer
        logic  ins_shift;   // move the read entry up one slot
        logic  ins_write;   // store the new entry
        logic  hd_latch;    // take the head entry, start remainder unit
        logic  div_step;    // one remainder step
        logic  grp;         // lower bound of the fire group
        logic  pop;         // drop the head entry
        logic  nxt_load;    // next head becomes the current entry
        logic  emit;        // load the output register
        t_kind kind;
        logic  last;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic ins_front;
        logic rd_ge;
        logic due;
        logic in_group;
        logic div_done;
        logic n_max;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/sdtq_dpath.sv =====
// Datapath: clock, circular entry memory, insert walk, remainder unit, output register.
module sdtq_dpath
    import sdtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_req_type,
    input  logic [DELAY_W-1:0] i_delay_ms,
    input  logic [TAG_W-1:0]   i_tag,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [1:0]         o_kind,
    output logic [TAG_W-1:0]   o_fired_tag,
    output logic               o_last
);

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DCNT_W = 2;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    // Entry memory
    logic [TIME_BITS-1:0] r_dl_mem  [QUEUE_DEPTH];
    logic [TAG_W-1:0]     r_tag_mem [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] r_rd_dl;
    logic [TAG_W-1:0]     r_rd_tag;

    // Queue control
    logic [TIME_BITS-1:0] r_now;
    logic [IDX_W-1:0]     r_head;
    logic [CNT_W-1:0]     r_count;

    // Set request path
    logic [DELAY_W-1:0]   r_delay;
    logic [TAG_W-1:0]     r_new_tag;
    logic [PROD_W-1:0]    r_prod;
    logic [TIME_BITS-1:0] r_new_dl;
    logic [IDX_W-1:0]     r_ins_p;
    logic [CNT_W-1:0]     r_ins_i;

    // Fire path
    logic [TIME_BITS-1:0] r_cur_dl;
    logic [TAG_W-1:0]     r_cur_tag;
    logic [SUM_W-1:0]     r_mod_acc;
    logic [REM_W-1:0]     r_rem;
    logic [DCNT_W-1:0]    r_div_cnt;
    logic [TIME_BITS-1:0] r_grp_lo;
    logic [N_W-1:0]       r_n;

    // Output register
    logic                 r_out_valid;
    t_kind                r_out_kind;
    logic [TAG_W-1:0]     r_out_tag;
    logic                 r_out_last;

    logic [CNT_W:0]       tail_sum;
    logic [IDX_W-1:0]     tail;
    logic [IDX_W-1:0]     ins_pm1;
    logic [IDX_W-1:0]     head_inc;
    logic [IDX_W-1:0]     rd_addr;
    logic [63:0]          cur_dl64;
    logic [SUM_W-1:0]     byte_sum;
    logic [15:0]          fold_a;
    logic [11:0]          fold_b;
    logic [10:0]          fold_c;
    logic [TIME_BITS-1:0] grp_dist;
    logic                 out_free;

    // Pointer arithmetic, modulo the queue depth
    assign tail_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
    assign tail     = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                    ? IDX_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
    assign ins_pm1  = (r_ins_p == '0) ? LAST_IDX : r_ins_p - 1'b1;
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign rd_addr  = i_cmd.ins_rd ? ins_pm1 : r_head;

    // Remainder unit: sum of byte residues, then three folds of 1024 into 24 and a subtraction of 1000
    assign cur_dl64 = 64'(r_cur_dl);

    always_comb begin
        byte_sum = '0;
        for (int b = 0; b < 8; b++) begin
            byte_sum = byte_sum
                     + SUM_W'(cur_dl64[8*b +: 8]) * SUM_W'(byte_weight(3'(b)));
        end
    end

    assign fold_a = 16'(r_mod_acc[SUM_W-1:10]) * 16'(FOLD_1024) + 16'(r_mod_acc[9:0]);
    assign fold_b = 12'(fold_a[15:10]) * 12'(FOLD_1024) + 12'(fold_a[9:0]);
    assign fold_c = 11'(r_mod_acc[11:10]) * 11'(FOLD_1024) + 11'(r_mod_acc[9:0]);

    assign grp_dist  = r_rd_dl - r_grp_lo;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Status back to the controller
    always_comb begin
        o_status.count_zero = (r_count == '0);
        o_status.count_full = (r_count == DEPTH_CNT);
        o_status.ins_front  = (r_ins_i == '0);
        o_status.rd_ge      = (r_rd_dl >= r_new_dl);
        o_status.due        = (r_now >= r_rd_dl);
        o_status.in_group   = (r_rd_dl >= r_grp_lo)
                            && (grp_dist < TIME_BITS'(US_PER_MS));
        o_status.div_done   = (r_div_cnt == DCNT_W'(REM_STEPS));
        o_status.n_max      = (r_n == N_W'(MAX_RESULTS));
        o_status.out_free   = out_free;
    end

    // Memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_shift) begin
            r_dl_mem[r_ins_p]  <= r_rd_dl;
            r_tag_mem[r_ins_p] <= r_rd_tag;
        end else if (i_cmd.ins_write) begin
            r_dl_mem[r_ins_p]  <= r_new_dl;
            r_tag_mem[r_ins_p] <= r_new_tag;
        end
        r_rd_dl  <= r_dl_mem[rd_addr];
        r_rd_tag <= r_tag_mem[rd_addr];
    end

    // Clock and queue occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now   <= '0;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.accept && i_req_type == REQ_TICK) begin
                r_now <= r_now + 1'b1;
            end
            if (i_cmd.ins_write) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop) begin
                r_count <= r_count - 1'b1;
                r_head  <= head_inc;
            end
        end
    end

    // Set request: deadline and the insert walk from the tail down
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_delay   <= i_delay_ms;
            r_new_tag <= i_tag;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_delay) * PROD_W'(US_PER_MS);
        end
        if (i_cmd.add) begin
            r_new_dl <= r_now + TIME_BITS'(r_prod);
            r_ins_p  <= tail;
            r_ins_i  <= r_count;
        end else if (i_cmd.ins_shift) begin
            r_ins_p <= ins_pm1;
            r_ins_i <= r_ins_i - 1'b1;
        end
    end

    // Fire group: head entry, millisecond remainder, group bound
    always_ff @(posedge i_clk) begin
        if (i_cmd.hd_latch) begin
            r_cur_dl  <= r_rd_dl;
            r_cur_tag <= r_rd_tag;
            r_div_cnt <= '0;
            r_n       <= '0;
        end else begin
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == '0) begin
                    r_mod_acc <= byte_sum;
                end else if (r_div_cnt == DCNT_W'(1)) begin
                    r_mod_acc <= SUM_W'(fold_b);
                end else if (fold_c >= 11'(US_PER_MS)) begin
                    r_rem <= REM_W'(fold_c - 11'(US_PER_MS));
                end else begin
                    r_rem <= REM_W'(fold_c);
                end
            end
            if (i_cmd.pop) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.nxt_load) begin
                r_cur_tag <= r_rd_tag;
            end
        end
        if (i_cmd.grp) begin
            r_grp_lo <= r_cur_dl - TIME_BITS'(r_rem);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= i_cmd.kind;
            r_out_tag  <= (i_cmd.kind == KIND_FIRED) ? r_cur_tag : '0;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_fired_tag = r_out_tag;
    assign o_last      = r_out_last;

endmodule

// ===== rtl/sdtq_ctrl.sv =====
// Controller state machine for the sorted deadline timer queue.
module sdtq_ctrl
    import sdtq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_req_type,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MUL       = 4'd1;
    localparam logic [3:0] S_ADD       = 4'd2;
    localparam logic [3:0] S_INS_CHK   = 4'd3;
    localparam logic [3:0] S_INS_CMP   = 4'd4;
    localparam logic [3:0] S_INS_WR    = 4'd5;
    localparam logic [3:0] S_EMIT_SET  = 4'd6;
    localparam logic [3:0] S_HD_RD     = 4'd7;
    localparam logic [3:0] S_HD_CMP    = 4'd8;
    localparam logic [3:0] S_DIV       = 4'd9;
    localparam logic [3:0] S_GRP       = 4'd10;
    localparam logic [3:0] S_POP       = 4'd11;
    localparam logic [3:0] S_NX_CHK    = 4'd12;
    localparam logic [3:0] S_NX_CMP    = 4'd13;
    localparam logic [3:0] S_EMIT_FIRE = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_kind      r_kind;
    t_kind      n_kind;
    logic       r_last;
    logic       n_last;

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_last  = r_last;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_req_type == REQ_TICK) begin
                        n_state = i_status.count_zero ? S_IDLE : S_HD_RD;
                    end else if (i_status.count_full) begin
                        n_kind  = KIND_FULL;
                        n_state = S_EMIT_SET;
                    end else begin
                        n_kind  = KIND_ACCEPT;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_INS_CHK;
            end
            S_INS_CHK: begin
                o_cmd.ins_rd = 1'b1;
                n_state = i_status.ins_front ? S_INS_WR : S_INS_CMP;
            end
            S_INS_CMP: begin
                // Entries at or past the new deadline move up one slot
                if (i_status.rd_ge) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state = S_INS_CHK;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.ins_write = 1'b1;
                n_state = S_EMIT_SET;
            end
            S_EMIT_SET: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = r_kind;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_HD_RD: begin
                n_state = S_HD_CMP;
            end
            S_HD_CMP: begin
                if (i_status.due) begin
                    o_cmd.hd_latch = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_GRP;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_GRP: begin
                o_cmd.grp = 1'b1;
                n_state   = S_POP;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_NX_CHK;
            end
            S_NX_CHK: begin
                if (i_status.count_zero || i_status.n_max) begin
                    n_last  = 1'b1;
                    n_state = S_EMIT_FIRE;
                end else begin
                    n_state = S_NX_CMP;
                end
            end
            S_NX_CMP: begin
                n_last  = !i_status.in_group;
                n_state = S_EMIT_FIRE;
            end
            S_EMIT_FIRE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_FIRED;
                    o_cmd.last = r_last;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.nxt_load = 1'b1;
                        n_state = S_POP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_ACCEPT;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_last  <= n_last;
        end
    end

endmodule

// ===== rtl/sorted_deadline_timer_queue_core.sv =====
// Top level of the sorted deadline timer queue.
//
// Channel  Direction  Handshake                Payload
// in       to block   i_in_valid / o_in_stall   i_req_type, i_delay_ms, i_tag
// out      from block o_out_valid / i_out_stall o_kind, o_fired_tag, o_last
//
// After acceptance o_in_stall stays high while a set computes the deadline and
// walks down from the tail, moving each entry at or past the new deadline up
// one slot, until the front or an earlier entry; a set on a full queue only
// reports full. A tick on an empty queue does not stall; else it reads the head
// and, if due, fires its millisecond group, at most 16. Output stalls extend it.
// Synchronous reset empties the queue and clears the clock.
module sorted_deadline_timer_queue_core
    import sdtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [DELAY_W-1:0] i_delay_ms,
    input  logic [TAG_W-1:0]   i_tag,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_kind,
    output logic [TAG_W-1:0]   o_fired_tag,
    output logic               o_last
);

    t_cmd    cmd;
    t_status status;

    // Sequencer
    sdtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Storage and arithmetic
    sdtq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_req_type  (i_req_type),
        .i_delay_ms  (i_delay_ms),
        .i_tag       (i_tag),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_fired_tag (o_fired_tag),
        .o_last      (o_last)
    );

endmodule
